// File: design/ese_pkg.sv
// Shared constants, types and byte-level helper functions for the escape sequence expander.
package ese_pkg;

  // Input byte codes that steer the parser
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_U         = 8'h75;
  localparam logic [7:0] CHR_X         = 8'h78;
  localparam logic [7:0] CHR_ZERO      = 8'h30;
  localparam logic [7:0] CHR_NINE      = 8'h39;

  // Surrogate and plane boundaries
  localparam logic [20:0] SURR_HIGH_LO = 21'h00D800;
  localparam logic [20:0] SURR_LOW_LO  = 21'h00DC00;
  localparam logic [20:0] SURR_END     = 21'h00E000;
  localparam logic [20:0] PLANE1_BASE  = 21'h010000;

  // Most bytes one input word can produce
  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned CNT_W     = 3;

  // Bytes produced by one input word, first byte in slot 0
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
  } ese_grp_t;

  // Digit value of a hex character; any other character keeps its raw code
  function automatic logic [7:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end
    return v;
  endfunction

  // Single-letter escapes b t n r f s; anything else stands for itself
  function automatic logic [7:0] simple_escape(input logic [7:0] b);
    logic [7:0] v;
    case (b)
      8'h62:   v = 8'h08;
      8'h74:   v = 8'h09;
      8'h6E:   v = 8'h0A;
      8'h72:   v = 8'h0D;
      8'h66:   v = 8'h0C;
      8'h73:   v = 8'h20;
      default: v = b;
    endcase
    return v;
  endfunction

  // One byte as a group
  function automatic ese_grp_t one_byte(input logic [7:0] b);
    ese_grp_t g;
    g.bytes    = '0;
    g.bytes[0] = b;
    g.cnt      = CNT_W'(1);
    return g;
  endfunction

  // UTF-8 encoding of a code value, 1 to 4 bytes
  function automatic ese_grp_t encode_utf8(input logic [20:0] x);
    ese_grp_t g;
    g.bytes = '0;
    if (x < 21'h80) begin
      g.bytes[0] = x[7:0];
      g.cnt      = CNT_W'(1);
    end else if (x < 21'h800) begin
      g.bytes[0] = {3'b110, x[10:6]};
      g.bytes[1] = {2'b10, x[5:0]};
      g.cnt      = CNT_W'(2);
    end else if (x < PLANE1_BASE) begin
      g.bytes[0] = {4'b1110, x[15:12]};
      g.bytes[1] = {2'b10, x[11:6]};
      g.bytes[2] = {2'b10, x[5:0]};
      g.cnt      = CNT_W'(3);
    end else begin
      g.bytes[0] = {5'b11110, x[20:18]};
      g.bytes[1] = {2'b10, x[17:12]};
      g.bytes[2] = {2'b10, x[11:6]};
      g.bytes[3] = {2'b10, x[5:0]};
      g.cnt      = CNT_W'(4);
    end
    return g;
  endfunction

endpackage

// File: design/ese_channels.sv
// Handshake channel interfaces for escaped input words and unescaped output words.
interface ese_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic [2:0] bytes_after;

  modport source (output valid, output text_byte, output bytes_after, input ready);
  modport sink   (input valid, input text_byte, input bytes_after, output ready);
endinterface

interface ese_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// File: design/ese_in_reg.sv
// Input register stage: holds one accepted word until the parser takes it.
module ese_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  ese_in_if.sink     in_ch,
  input  logic       step,
  output logic       word_valid,
  output logic [7:0] word_byte,
  output logic [2:0] word_after
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic [2:0] after_r;

  // Take a new word when the stage is empty or being drained this cycle
  assign in_ch.ready = !valid_r || step;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r  <= in_ch.text_byte;
      after_r <= in_ch.bytes_after;
    end
  end

  assign word_valid = valid_r;
  assign word_byte  = byte_r;
  assign word_after = after_r;

endmodule

// File: design/ese_core.sv
// Escape parser: state registers and the single-pass decode of one word into output bytes.
module ese_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        word_byte,
  input  logic [2:0]        word_after,
  output ese_pkg::ese_grp_t grp
);

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_UHEX,
    MODE_XHEX,
    MODE_NIB
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [15:0] pend_r, pend_nxt;

  logic [7:0]  hv;
  logic [20:0] uacc;
  logic [7:0]  xacc;
  logic [20:0] joined;
  logic        is_high;
  logic        is_low;

  // Shared digit arithmetic
  always_comb begin
    hv      = ese_pkg::hex_value(word_byte);
    uacc    = {acc_r[16:0], 4'h0} + {13'd0, hv};
    xacc    = {acc_r[3:0], 4'h0} + hv;
    is_high = (uacc >= ese_pkg::SURR_HIGH_LO) && (uacc < ese_pkg::SURR_LOW_LO);
    is_low  = (uacc >= ese_pkg::SURR_LOW_LO) && (uacc < ese_pkg::SURR_END);
    joined  = {1'b0, pend_r[9:0], uacc[9:0]} + ese_pkg::PLANE1_BASE;
  end

  // Next state and output group for the word in the input register
  always_comb begin
    mode_nxt  = mode_r;
    dcnt_nxt  = dcnt_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    grp.bytes = '0;
    grp.cnt   = '0;
    case (mode_r)
      MODE_ESC: begin
        if (word_byte == ese_pkg::CHR_U && word_after >= 3'd4) begin
          mode_nxt = MODE_UHEX;
          dcnt_nxt = 2'd0;
          acc_nxt  = '0;
        end else if (word_byte == ese_pkg::CHR_X && word_after >= 3'd2) begin
          mode_nxt = MODE_XHEX;
          dcnt_nxt = 2'd0;
          acc_nxt  = '0;
        end else if (word_byte >= ese_pkg::CHR_ZERO && word_byte <= ese_pkg::CHR_NINE &&
                     word_after >= 3'd1) begin
          mode_nxt = MODE_NIB;
          acc_nxt  = {17'd0, word_byte[3:0]};
        end else begin
          pend_nxt = '0;
          grp      = ese_pkg::one_byte(ese_pkg::simple_escape(word_byte));
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_UHEX: begin
        if (dcnt_r == 2'd3) begin
          mode_nxt = MODE_PLAIN;
          dcnt_nxt = 2'd0;
          acc_nxt  = '0;
          if (is_high) begin
            // Hold the high half; it emits nothing until its partner arrives
            pend_nxt = uacc[15:0];
          end else if (is_low && pend_r != 16'd0) begin
            pend_nxt = '0;
            grp      = ese_pkg::encode_utf8(joined);
          end else begin
            grp = ese_pkg::encode_utf8(uacc);
          end
        end else begin
          acc_nxt  = uacc;
          dcnt_nxt = dcnt_r + 2'd1;
        end
      end
      MODE_XHEX: begin
        if (dcnt_r != 2'd0) begin
          mode_nxt = MODE_PLAIN;
          dcnt_nxt = 2'd0;
          acc_nxt  = '0;
          grp      = ese_pkg::one_byte(xacc);
        end else begin
          acc_nxt  = {13'd0, xacc};
          dcnt_nxt = dcnt_r + 2'd1;
        end
      end
      MODE_NIB: begin
        grp      = ese_pkg::one_byte({acc_r[3:0], 4'h0} | (word_byte - ese_pkg::CHR_ZERO));
        mode_nxt = MODE_PLAIN;
        acc_nxt  = '0;
      end
      default: begin
        if (word_byte == ese_pkg::CHR_BACKSLASH && word_after >= 3'd1) begin
          mode_nxt = MODE_ESC;
        end else begin
          mode_nxt = MODE_PLAIN;
          pend_nxt = '0;
          grp      = ese_pkg::one_byte(word_byte);
        end
      end
    endcase
    // Drop all state at the end of a string
    if (word_after == 3'd0) begin
      mode_nxt = MODE_PLAIN;
      dcnt_nxt = '0;
      acc_nxt  = '0;
      pend_nxt = '0;
    end
  end

  // Advance state once per word taken from the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      dcnt_r <= '0;
      acc_r  <= '0;
      pend_r <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      dcnt_r <= dcnt_nxt;
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// File: design/ese_out_buf.sv
// Result register: holds the bytes of one decoded word and hands them out one byte at a time.
module ese_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ese_pkg::ese_grp_t grp,
  output logic              can_load,
  ese_out_if.source         out_ch
);

  logic [ese_pkg::MAX_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic [ese_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                               pop;
  logic                               load;

  assign pop      = out_ch.valid && out_ch.ready;
  assign can_load = (cnt_r == '0) || ((cnt_r == ese_pkg::CNT_W'(1)) && pop);
  assign load     = step && (grp.cnt != '0);

  // Load a fresh group, or shift out the byte just taken
  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      bytes_nxt = grp.bytes;
      cnt_nxt   = grp.cnt;
    end else if (pop) begin
      bytes_nxt = {8'h00, bytes_r[ese_pkg::MAX_BYTES-1:1]};
      cnt_nxt   = cnt_r - ese_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.out_byte = bytes_r[0];
  assign out_ch.run_last = (cnt_r == ese_pkg::CNT_W'(1));

endmodule

// File: design/escape_sequence_expander.sv
// Top level of the backslash escape expander: input register, parser and result register.
//
//   channel  | dir | payload                      | handshake
//   in_ch    | in  | text_byte[8], bytes_after[3] | valid / ready
//   out_ch   | out | out_byte[8], run_last[1]     | valid / ready
//
// An accepted word waits in the input register, is decoded from there in one pass and is
// loaded into the result register once it is free, and from there its first byte is offered.
// One input word per cycle is sustained while each word yields at most one byte and out_ch
// is ready; a word of 2..4 UTF-8 bytes holds the parser until out_ch takes its last byte.
// rst_n is synchronous, active low, and returns the parser to plain text.
// A stall on out_ch backs up through the result register into in_ch.ready.
module escape_sequence_expander (
  input  logic       clk,
  input  logic       rst_n,
  ese_in_if.sink     in_ch,
  ese_out_if.source  out_ch
);

  logic              word_valid;
  logic [7:0]        word_byte;
  logic [2:0]        word_after;
  logic              can_load;
  logic              step;
  ese_pkg::ese_grp_t grp;

  assign step = word_valid && can_load;

  ese_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .step       (step),
    .word_valid (word_valid),
    .word_byte  (word_byte),
    .word_after (word_after)
  );

  ese_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .word_byte  (word_byte),
    .word_after (word_after),
    .grp        (grp)
  );

  ese_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .grp      (grp),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
